>>> src/mbss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbss_pkg: shared types and constants of the masked byte signature scanner
// Result codes, text characters, controller states and the command and status
// groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package mbss_pkg;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_ERR   = 2'd1;
  localparam logic [1:0] STATUS_MATCH = 2'd2;
  localparam logic [1:0] STATUS_NONE  = 2'd3;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;

  localparam logic [7:0] NIB_LO = 8'h0F;
  localparam logic [7:0] NIB_HI = 8'hF0;

  // nibble code 16 marks a character that is not a hex digit
  localparam logic [4:0] NIB_BAD = 5'd16;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_EMIT
  } ctl_state_t;

  typedef struct packed {
    logic       take;
    logic       cmp_start;
    logic       cmp_run;
    logic       set_reported;
    logic       scan_clear;
    logic       out_load;
    logic [1:0] code;
  } ctl_cmd_t;

  typedef struct packed {
    logic term;
    logic good;
    logic is_region;
    logic is_last;
    logic cmp_go;
    logic reported;
    logic cmp_hit;
    logic cmp_miss;
  } dp_stat_t;

  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    logic [4:0] n;
    n = NIB_BAD;
    if (c >= CH_0 && c <= CH_9) begin
      n = 5'(c - CH_0);
    end else if (c >= CH_LA && c <= CH_LF) begin
      n = 5'(8'd10 + (c - CH_LA));
    end else if (c >= CH_UA && c <= CH_UF) begin
      n = 5'(8'd10 + (c - CH_UA));
    end
    return n;
  endfunction

endpackage

>>> src/mbss_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbss_if: valid/ready channels of the signature scanner
// Input item channel, result channel and base address write channel.
// ----------------------------------------------------------------------------
interface mbss_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] value;
  logic       last;

  modport source (output valid, action, value, last, input ready);
  modport sink   (input valid, action, value, last, output ready);
endinterface

interface mbss_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [6:0]  pattern_length;
  logic [47:0] match_address;

  modport source (output valid, status, pattern_length, match_address, input ready);
  modport sink   (input valid, status, pattern_length, match_address, output ready);
endinterface

interface mbss_cfg_if;
  logic        valid;
  logic        ready;
  logic [47:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

>>> src/mbss_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbss_ctrl: controller of the signature scanner
// Takes input beats, runs the window compare and hands results to the output
// register.
// ----------------------------------------------------------------------------
module mbss_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  mbss_pkg::dp_stat_t stat,
  output mbss_pkg::ctl_cmd_t cmd
);
  import mbss_pkg::*;

  ctl_state_t state_r, state_nxt;
  logic [1:0] code_r, code_nxt;
  logic       clr_r, clr_nxt;
  logic       last_r, last_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      code_r      <= STATUS_OK;
      clr_r       <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      code_r      <= code_nxt;
      clr_r       <= clr_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    code_nxt      = code_r;
    clr_nxt       = clr_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take = 1'b1;
          if (stat.term) begin
            code_nxt  = stat.good ? STATUS_OK : STATUS_ERR;
            clr_nxt   = 1'b0;
            state_nxt = S_EMIT;
          end else if (stat.is_region) begin
            if (stat.cmp_go) begin
              cmd.cmp_start = 1'b1;
              last_nxt      = stat.is_last;
              state_nxt     = S_CMP;
            end else if (stat.is_last) begin
              if (stat.reported) begin
                cmd.scan_clear = 1'b1;
              end else begin
                code_nxt  = STATUS_NONE;
                clr_nxt   = 1'b1;
                state_nxt = S_EMIT;
              end
            end
          end
        end
      end
      S_CMP: begin
        cmd.cmp_run = 1'b1;
        if (stat.cmp_hit) begin
          cmd.set_reported = 1'b1;
          code_nxt         = STATUS_MATCH;
          clr_nxt          = last_r;
          state_nxt        = S_EMIT;
        end else if (stat.cmp_miss) begin
          if (last_r) begin
            code_nxt  = STATUS_NONE;
            clr_nxt   = 1'b1;
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_EMIT: begin
        // wait for a free output register, then end the scan if the beat was final
        if (!out_valid_r || out_ready) begin
          cmd.out_load   = 1'b1;
          cmd.code       = code_r;
          cmd.scan_clear = clr_r;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

>>> src/mbss_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbss_datapath: text parser, pattern memory, byte window and compare
// Builds masked pattern bytes from text beats, keeps the recent region bytes
// in a ring memory and compares one pattern byte per cycle.
// ----------------------------------------------------------------------------
module mbss_datapath #(
  parameter int MAX_PATTERN_BYTES = 64,
  parameter int OFFSET_BITS       = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mbss_pkg::ctl_cmd_t cmd,
  output mbss_pkg::dp_stat_t stat,
  input  logic               in_action,
  input  logic [7:0]         in_value,
  input  logic               in_last,
  input  logic               cfg_we,
  input  logic [47:0]        cfg_data,
  output logic [1:0]         out_status,
  output logic [6:0]         out_pattern_length,
  output logic [47:0]        out_match_address
);
  import mbss_pkg::*;

  localparam int LEN_W = $clog2(MAX_PATTERN_BYTES + 1);
  localparam int IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
  localparam int RING  = 1 << IDX_W;
  localparam int BS_W  = OFFSET_BITS + 1;

  // pattern memory entry: value in the high byte, mask in the low byte
  logic [15:0] pat_mem [MAX_PATTERN_BYTES];
  logic [7:0]  ring_mem [RING];

  logic             tip_r, tip_nxt;
  logic [LEN_W-1:0] hl_r, hl_nxt;
  logic             err_r, err_nxt;
  logic             rdy_r, rdy_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic [7:0]       first_r, first_nxt;
  logic [7:0]       second_r, second_nxt;
  logic [BS_W-1:0]  bs_r, bs_nxt;
  logic             rep_r, rep_nxt;
  logic [IDX_W-1:0] wptr_r, wptr_nxt;
  logic [47:0]      base_r, base_nxt;
  logic [LEN_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0] win_ptr_r, win_ptr_nxt;
  logic             issue_r, issue_nxt;
  logic             dv_r, dv_nxt;
  logic             dlast_r, dlast_nxt;
  logic [15:0]      pat_q_r;
  logic [7:0]       win_q_r;
  logic [1:0]       ost_r;
  logic [6:0]       olen_r;
  logic [47:0]      oaddr_r;

  // text parsing view, with a fresh signature starting from cleared state
  logic [LEN_W-1:0] eff_hl, hl_after, hl_m1;
  logic             eff_err, err_after;
  logic [1:0]       eff_cnt;
  logic [7:0]       eff_first, eff_second;
  logic [4:0]       n1, n2;
  logic             ok1, ok2, tok_ok, tok_store, tok_err, is_sep, is_nul;
  logic [7:0]       tok_val, tok_msk;
  logic             take_text, take_region;
  logic             in_range;
  logic [BS_W-1:0]  bs_inc;
  logic             mism;
  logic [47:0]      match_addr;
  logic [BS_W-1:0]  offs;

  assign take_text   = cmd.take && !in_action;
  assign take_region = cmd.take && in_action;

  assign eff_hl     = tip_r ? hl_r : '0;
  assign eff_err    = tip_r && err_r;
  assign eff_cnt    = tip_r ? cnt_r : 2'd0;
  assign eff_first  = tip_r ? first_r : CH_NUL;
  assign eff_second = tip_r ? second_r : CH_NUL;

  assign is_nul = (in_value == CH_NUL);
  assign is_sep = is_nul || (in_value == CH_SPACE);

  assign n1  = nibble_of(eff_first);
  assign n2  = nibble_of(eff_second);
  assign ok1 = (n1 != NIB_BAD) || (eff_first == CH_QMARK);
  assign ok2 = (n2 != NIB_BAD) || (eff_second == CH_QMARK);

  always_comb begin
    tok_ok  = 1'b0;
    tok_val = 8'h00;
    tok_msk = 8'h00;
    case (eff_cnt)
      2'd1: begin
        tok_ok = ok1;
        if (n1 != NIB_BAD) begin
          tok_val = {4'h0, n1[3:0]};
          tok_msk = NIB_LO;
        end
      end
      2'd2: begin
        tok_ok = ok1 && ok2;
        if (n1 != NIB_BAD) begin
          tok_val = tok_val | {n1[3:0], 4'h0};
          tok_msk = tok_msk | NIB_HI;
        end
        if (n2 != NIB_BAD) begin
          tok_val = tok_val | {4'h0, n2[3:0]};
          tok_msk = tok_msk | NIB_LO;
        end
      end
      default: begin
        tok_ok = 1'b0;
      end
    endcase
  end

  assign tok_store = is_sep && (eff_cnt != 2'd0) && tok_ok &&
                     (eff_hl < LEN_W'(MAX_PATTERN_BYTES));
  assign tok_err   = is_sep && (eff_cnt != 2'd0) && !tok_store;
  assign hl_after  = eff_hl + LEN_W'(tok_store);
  assign err_after = eff_err || tok_err;
  assign hl_m1     = hl_r - LEN_W'(1);

  // offsets past the counter range never match, and the count saturates
  assign in_range = !bs_r[OFFSET_BITS];
  assign bs_inc   = in_range ? bs_r + BS_W'(1) : bs_r;

  assign mism = |((win_q_r ^ pat_q_r[15:8]) & pat_q_r[7:0]);

  assign stat.term      = !in_action && is_nul;
  assign stat.good      = !err_after && (hl_after != '0);
  assign stat.is_region = in_action;
  assign stat.is_last   = in_action && in_last;
  assign stat.cmp_go    = in_action && rdy_r && !rep_r && in_range && (hl_r != '0) &&
                          (bs_inc >= BS_W'(hl_r));
  assign stat.reported  = rep_r;
  assign stat.cmp_hit   = dv_r && !mism && dlast_r;
  assign stat.cmp_miss  = dv_r && mism;

  always_comb begin
    tip_nxt     = tip_r;
    hl_nxt      = hl_r;
    err_nxt     = err_r;
    rdy_nxt     = rdy_r;
    cnt_nxt     = cnt_r;
    first_nxt   = first_r;
    second_nxt  = second_r;
    bs_nxt      = bs_r;
    rep_nxt     = rep_r;
    wptr_nxt    = wptr_r;
    base_nxt    = cfg_we ? cfg_data : base_r;
    rd_idx_nxt  = rd_idx_r;
    win_ptr_nxt = win_ptr_r;
    issue_nxt   = issue_r;
    dv_nxt      = dv_r;
    dlast_nxt   = dlast_r;

    if (take_text) begin
      tip_nxt = !is_nul;
      hl_nxt  = hl_after;
      err_nxt = err_after;
      if (is_nul) begin
        rdy_nxt = stat.good;
      end else if (!tip_r) begin
        rdy_nxt = 1'b0;
      end
      if (is_sep) begin
        cnt_nxt    = 2'd0;
        first_nxt  = CH_NUL;
        second_nxt = CH_NUL;
      end else begin
        first_nxt  = (eff_cnt == 2'd0) ? in_value : eff_first;
        second_nxt = (eff_cnt == 2'd1) ? in_value : eff_second;
        cnt_nxt    = (eff_cnt == 2'd3) ? 2'd3 : eff_cnt + 2'd1;
      end
      if (!tip_r) begin
        bs_nxt  = '0;
        rep_nxt = 1'b0;
      end
    end

    if (take_region) begin
      bs_nxt   = bs_inc;
      wptr_nxt = wptr_r + IDX_W'(1);
    end

    if (cmd.cmp_start) begin
      // oldest byte of the window that ends at the byte written this cycle
      rd_idx_nxt  = '0;
      win_ptr_nxt = wptr_r + IDX_W'(1) - hl_r[IDX_W-1:0];
      issue_nxt   = 1'b1;
      dv_nxt      = 1'b0;
      dlast_nxt   = 1'b0;
    end else if (cmd.cmp_run) begin
      dv_nxt = issue_r;
      if (issue_r) begin
        rd_idx_nxt  = rd_idx_r + LEN_W'(1);
        win_ptr_nxt = win_ptr_r + IDX_W'(1);
        dlast_nxt   = (rd_idx_r == hl_m1);
        issue_nxt   = (rd_idx_r != hl_m1);
      end
    end

    if (cmd.set_reported) begin
      rep_nxt = 1'b1;
    end
    if (cmd.scan_clear) begin
      bs_nxt  = '0;
      rep_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tip_r    <= 1'b0;
      hl_r     <= '0;
      err_r    <= 1'b0;
      rdy_r    <= 1'b0;
      cnt_r    <= 2'd0;
      first_r  <= CH_NUL;
      second_r <= CH_NUL;
      bs_r     <= '0;
      rep_r    <= 1'b0;
      wptr_r   <= '0;
      base_r   <= '0;
      issue_r  <= 1'b0;
      dv_r     <= 1'b0;
      dlast_r  <= 1'b0;
    end else begin
      tip_r    <= tip_nxt;
      hl_r     <= hl_nxt;
      err_r    <= err_nxt;
      rdy_r    <= rdy_nxt;
      cnt_r    <= cnt_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
      bs_r     <= bs_nxt;
      rep_r    <= rep_nxt;
      wptr_r   <= wptr_nxt;
      base_r   <= base_nxt;
      issue_r  <= issue_nxt;
      dv_r     <= dv_nxt;
      dlast_r  <= dlast_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r  <= rd_idx_nxt;
    win_ptr_r <= win_ptr_nxt;
  end

  always_ff @(posedge clk) begin
    if (take_text && tok_store) begin
      pat_mem[eff_hl[IDX_W-1:0]] <= {tok_val, tok_msk};
    end
  end

  always_ff @(posedge clk) begin
    if (take_region) begin
      ring_mem[wptr_r] <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cmp_run && issue_r) begin
      pat_q_r <= pat_mem[rd_idx_r[IDX_W-1:0]];
      win_q_r <= ring_mem[win_ptr_r];
    end
  end

  assign offs       = bs_r - BS_W'(hl_r);
  assign match_addr = base_r + 48'(offs);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      ost_r   <= cmd.code;
      olen_r  <= 7'(hl_r);
      oaddr_r <= (cmd.code == STATUS_MATCH) ? match_addr : 48'd0;
    end
  end

  assign out_status         = ost_r;
  assign out_pattern_length = olen_r;
  assign out_match_address  = oaddr_r;

endmodule

>>> src/masked_byte_signature_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_byte_signature_scanner: masked byte pattern search over a region
// Parses a hex text signature into masked bytes, then scans region bytes for
// the first position where all masked bytes match.
// ----------------------------------------------------------------------------
// Usage:
//   in_bus  carries one beat per text character (action 0) or region byte
//           (action 1, last marks the final byte of a region).
//   out_bus returns at most one result per input beat: pattern ok/error at
//           the text terminator, match address, or no match at the last byte.
//   cfg_bus writes region_base and is always ready; the user must write it
//           only while idle, as the block itself does not enforce this.
//   a text character is taken in the idle state; the terminator goes through
//   the emit state for its result. A region byte with a compare due goes on to
//   the window compare, which reads one pattern byte and one window byte per
//   cycle from the two memories while no new beat is taken.
// Reset clears the parser, the scan state, region_base and the output valid flag;
// pattern and window memories need no clearing.
// A stalled receiver holds the result in the output register; the next beat is
// still taken and processed, and only a second result waits for the register.
// ----------------------------------------------------------------------------
module masked_byte_signature_scanner #(
  parameter int MAX_PATTERN_BYTES = 64,
  parameter int OFFSET_BITS       = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  mbss_in_if.sink    in_bus,
  mbss_out_if.source out_bus,
  mbss_cfg_if.sink   cfg_bus
);
  import mbss_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  assign cfg_bus.ready = 1'b1;

  mbss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_ready  (in_bus.ready),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mbss_datapath #(
    .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
    .OFFSET_BITS       (OFFSET_BITS)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_action          (in_bus.action),
    .in_value           (in_bus.value),
    .in_last            (in_bus.last),
    .cfg_we             (cfg_bus.valid),
    .cfg_data           (cfg_bus.data),
    .out_status         (out_bus.status),
    .out_pattern_length (out_bus.pattern_length),
    .out_match_address  (out_bus.match_address)
  );

endmodule
